// ----- sv/lbe_pkg.sv -----
// Shared types and constants for the line buffer editor.
`default_nettype none

package lbe_pkg;

  // Command codes
  localparam logic [2:0] CMD_WRITE = 3'd0;
  localparam logic [2:0] CMD_LEFT  = 3'd1;
  localparam logic [2:0] CMD_RIGHT = 3'd2;
  localparam logic [2:0] CMD_UPPER = 3'd3;
  localparam logic [2:0] CMD_LOWER = 3'd4;
  localparam logic [2:0] CMD_BKSP  = 3'd5;
  localparam logic [2:0] CMD_PRINT = 3'd6;

  // Result kinds
  localparam logic [1:0] KIND_ECHO   = 2'd0;
  localparam logic [1:0] KIND_REDRAW = 2'd1;
  localparam logic [1:0] KIND_PRINT  = 2'd2;
  localparam logic [1:0] KIND_CURSOR = 2'd3;

  // ASCII letter bounds and case offset
  localparam logic [7:0] CH_LOW_A  = 8'h61;
  localparam logic [7:0] CH_LOW_Z  = 8'h7A;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;
  localparam logic [7:0] CASE_DIFF = 8'd32;

  // Line length after reset
  localparam logic [6:0] LEN_RESET = 7'd64;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] char_code;
  } in_req_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] char_out;
    logic [5:0] column;
    logic [6:0] cursor_pos;
    logic       last;
  } out_res_t;

endpackage

`default_nettype wire

// ----- sv/lbe_line_mem.sv -----
// Character store: one write port, one registered read port, entries read as zero until written.
`default_nettype none

module lbe_line_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [7:0]    wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [7:0]    rd_data
);

  logic [7:0]       mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [7:0]       rd_q_r;
  logic             rd_vld_r;

  // Write the array
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Mark entries written since reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  // Register the read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q_r   <= mem[rd_addr];
      rd_vld_r <= vld_r[rd_addr];
    end
  end

  // Unwritten entries read as zero
  assign rd_data = rd_vld_r ? rd_q_r : 8'd0;

endmodule

`default_nettype wire

// ----- sv/line_buffer_editor.sv -----
// Top level: one-line edit buffer with cursor, sequenced over a single character memory.
// Write, left, right, unknown commands and commands with nothing to do give one result
// the cycle after start; a case change reads the cell, then writes it back and registers its result.
// Backspace and print read ahead through the memory's registered port, then give one result per
// cycle (line length minus the stepped-back cursor, or line length); busy stays high until the
// last result is issued, so no new request is taken before then. Reset clears the cursor, sets the line
// length to 64 and makes every cell read as zero. The receiver cannot stall (one-cycle out_valid).
`default_nettype none

module line_buffer_editor #(
  parameter int MAX_LEN = 64
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire lbe_pkg::in_req_t  in_req,
  output logic                   out_valid,
  output lbe_pkg::out_res_t      out_res,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [6:0]        cfg_data
);

  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CW = $clog2(MAX_LEN + 1);
  localparam int XW = CW + 1;
  localparam int LW = (XW > 7) ? XW : 7;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CASE  = 2'd1;
  localparam logic [1:0] ST_SHIFT = 2'd2;
  localparam logic [1:0] ST_PRINT = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [CW-1:0]     cursor_r, cursor_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;
  logic [2:0]        cmd_r, cmd_nxt;
  logic [6:0]        len_cfg_r;
  logic              out_valid_r, out_valid_nxt;
  lbe_pkg::out_res_t out_res_r, out_res_nxt;

  logic [CW-1:0] len_l;
  logic [CW-1:0] cur_c;
  logic [CW-1:0] cur_bs;
  logic          cur_lt;
  logic [XW-1:0] idx_p1;
  logic [XW-1:0] idx_p2;
  logic [XW-1:0] bs_p1;
  logic [XW-1:0] len_x;
  logic          accept;

  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [7:0]    mem_wd;
  logic          mem_re;
  logic [AW-1:0] mem_ra;
  logic [7:0]    mem_rd;
  logic [7:0]    case_ch;
  logic [7:0]    shift_ch;

  lbe_line_mem #(
    .DEPTH (MAX_LEN),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (mem_we),
    .wr_addr (mem_wa),
    .wr_data (mem_wd),
    .rd_en   (mem_re),
    .rd_addr (mem_ra),
    .rd_data (mem_rd)
  );

  // Configuration is always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_cfg_r <= lbe_pkg::LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      len_cfg_r <= cfg_data;
    end
  end

  // Effective length and clamped cursor
  assign len_l  = (LW'(len_cfg_r) > LW'(MAX_LEN)) ? CW'(MAX_LEN) : CW'(len_cfg_r);
  assign cur_c  = (cursor_r > len_l) ? len_l : cursor_r;
  assign cur_lt = (cur_c < len_l);
  assign cur_bs = (cur_c != '0) ? (cur_c - CW'(1)) : cur_c;
  assign bs_p1  = XW'(cur_bs) + XW'(1);
  assign idx_p1 = XW'(idx_r) + XW'(1);
  assign idx_p2 = XW'(idx_r) + XW'(2);
  assign len_x  = XW'(len_l);

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  // Case conversion of the cell under the cursor
  always_comb begin
    case_ch = mem_rd;
    if (cmd_r == lbe_pkg::CMD_UPPER && mem_rd >= lbe_pkg::CH_LOW_A
        && mem_rd <= lbe_pkg::CH_LOW_Z) begin
      case_ch = mem_rd - lbe_pkg::CASE_DIFF;
    end else if (cmd_r == lbe_pkg::CMD_LOWER && mem_rd >= lbe_pkg::CH_UP_A
                 && mem_rd <= lbe_pkg::CH_UP_Z) begin
      case_ch = mem_rd + lbe_pkg::CASE_DIFF;
    end
  end

  // Shift source: next cell, or zero past the end
  assign shift_ch = (idx_p1 < len_x) ? mem_rd : 8'd0;

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    cursor_nxt    = cursor_r;
    idx_nxt       = idx_r;
    cmd_nxt       = cmd_r;
    out_valid_nxt = 1'b0;
    out_res_nxt   = out_res_r;
    mem_we        = 1'b0;
    mem_wa        = idx_r[AW-1:0];
    mem_wd        = shift_ch;
    mem_re        = 1'b0;
    mem_ra        = idx_p2[AW-1:0];

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cursor_nxt             = cur_c;
          cmd_nxt                = in_req.cmd;
          out_valid_nxt          = 1'b1;
          out_res_nxt.kind       = lbe_pkg::KIND_CURSOR;
          out_res_nxt.char_out   = 8'd0;
          out_res_nxt.column     = 6'd0;
          out_res_nxt.last       = 1'b1;
          case (in_req.cmd)
            lbe_pkg::CMD_WRITE: begin
              if (cur_lt) begin
                mem_we               = 1'b1;
                mem_wa               = cur_c[AW-1:0];
                mem_wd               = in_req.char_code;
                cursor_nxt           = cur_c + CW'(1);
                out_res_nxt.kind     = lbe_pkg::KIND_ECHO;
                out_res_nxt.char_out = in_req.char_code;
                out_res_nxt.column   = 6'(cur_c);
              end
            end
            lbe_pkg::CMD_LEFT: begin
              cursor_nxt = cur_bs;
            end
            lbe_pkg::CMD_RIGHT: begin
              if (cur_lt) begin
                cursor_nxt = cur_c + CW'(1);
              end
            end
            lbe_pkg::CMD_UPPER, lbe_pkg::CMD_LOWER: begin
              if (cur_lt) begin
                mem_re        = 1'b1;
                mem_ra        = cur_c[AW-1:0];
                idx_nxt       = cur_c;
                out_valid_nxt = 1'b0;
                state_nxt     = ST_CASE;
              end
            end
            lbe_pkg::CMD_BKSP: begin
              cursor_nxt = cur_bs;
              if (cur_bs < len_l) begin
                mem_re        = (bs_p1 < len_x);
                mem_ra        = bs_p1[AW-1:0];
                idx_nxt       = cur_bs;
                out_valid_nxt = 1'b0;
                state_nxt     = ST_SHIFT;
              end
            end
            lbe_pkg::CMD_PRINT: begin
              if (len_l != '0) begin
                mem_re        = 1'b1;
                mem_ra        = '0;
                idx_nxt       = '0;
                out_valid_nxt = 1'b0;
                state_nxt     = ST_PRINT;
              end
            end
            default: begin
              cursor_nxt = cur_c;
            end
          endcase
          out_res_nxt.cursor_pos = 7'(cursor_nxt);
        end
      end

      ST_CASE: begin
        // Modify the cell and write it back
        mem_we                 = 1'b1;
        mem_wa                 = idx_r[AW-1:0];
        mem_wd                 = case_ch;
        out_valid_nxt          = 1'b1;
        out_res_nxt.kind       = lbe_pkg::KIND_ECHO;
        out_res_nxt.char_out   = case_ch;
        out_res_nxt.column     = 6'(idx_r);
        out_res_nxt.cursor_pos = 7'(cursor_r);
        out_res_nxt.last       = 1'b1;
        state_nxt              = ST_IDLE;
      end

      ST_SHIFT: begin
        // Pull the next cell down one place; read two ahead
        mem_we                 = 1'b1;
        mem_wa                 = idx_r[AW-1:0];
        mem_wd                 = shift_ch;
        out_valid_nxt          = 1'b1;
        out_res_nxt.kind       = lbe_pkg::KIND_REDRAW;
        out_res_nxt.char_out   = shift_ch;
        out_res_nxt.column     = 6'(idx_r);
        out_res_nxt.cursor_pos = 7'(cursor_r);
        out_res_nxt.last       = !(idx_p1 < len_x);
        if (idx_p1 < len_x) begin
          idx_nxt = idx_r + CW'(1);
          mem_re  = (idx_p2 < len_x);
          mem_ra  = idx_p2[AW-1:0];
        end else begin
          state_nxt = ST_IDLE;
        end
      end

      ST_PRINT: begin
        // Emit the cell read last cycle, fetch the next
        out_valid_nxt          = 1'b1;
        out_res_nxt.kind       = lbe_pkg::KIND_PRINT;
        out_res_nxt.char_out   = mem_rd;
        out_res_nxt.column     = 6'(idx_r);
        out_res_nxt.cursor_pos = 7'(cursor_r);
        out_res_nxt.last       = (idx_p1 == len_x);
        if (idx_p1 < len_x) begin
          idx_nxt = idx_r + CW'(1);
          mem_re  = 1'b1;
          mem_ra  = idx_p1[AW-1:0];
        end else begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cursor_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cursor_r    <= cursor_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    cmd_r     <= cmd_nxt;
    out_res_r <= out_res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

`default_nettype wire

// ----- tb/line_buffer_editor_test.sv -----
// Self-checking testbench for the line buffer editor: keystroke stimulus and result scoreboard.
`timescale 1ns / 100ps

module line_buffer_editor_test;

  localparam int LINE_CELLS = 64;
  localparam logic [2:0] CMD_UNUSED = 3'd7;
  // Quiet cycles after the last result before a length change or the end
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 20;

  // Expected keystroke results, computed from a private copy of the line
  class line_scoreboard;
    lbe_pkg::out_res_t pending_results[$];
    logic [7:0] cells [LINE_CELLS];
    logic [6:0] cursor;
    logic [6:0] line_len;
    int errors;
    int keystrokes;
    int results;

    function new();
      foreach (cells[i]) cells[i] = 8'h00;
      cursor = 7'd0;
      line_len = lbe_pkg::LEN_RESET;
      errors = 0;
      keystrokes = 0;
      results = 0;
    endfunction

    function void set_length(logic [6:0] value);
      line_len = value;
    endfunction

    function void push_result(logic [1:0] kind, logic [7:0] ch, int col, bit is_last);
      lbe_pkg::out_res_t r;
      r.kind = kind;
      r.char_out = ch;
      r.column = 6'(col);
      r.cursor_pos = cursor;
      r.last = is_last;
      pending_results.push_back(r);
    endfunction

    // Apply one accepted request to the line and queue what it emits
    function void note_keystroke(lbe_pkg::in_req_t req);
      int len;
      int i;
      logic [7:0] c;
      len = (line_len > 7'(LINE_CELLS)) ? LINE_CELLS : int'(line_len);
      keystrokes++;
      if (int'(cursor) > len) cursor = 7'(len);
      case (req.cmd)
        lbe_pkg::CMD_WRITE: begin
          if (int'(cursor) < len) begin
            i = int'(cursor);
            cells[i] = req.char_code;
            cursor = 7'(i + 1);
            push_result(lbe_pkg::KIND_ECHO, req.char_code, i, 1'b1);
            return;
          end
        end
        lbe_pkg::CMD_LEFT: begin
          if (cursor > 0) cursor = cursor - 7'd1;
        end
        lbe_pkg::CMD_RIGHT: begin
          if (int'(cursor) < len) cursor = cursor + 7'd1;
        end
        lbe_pkg::CMD_UPPER, lbe_pkg::CMD_LOWER: begin
          if (int'(cursor) < len) begin
            c = cells[cursor];
            if (req.cmd == lbe_pkg::CMD_UPPER && c >= lbe_pkg::CH_LOW_A
                && c <= lbe_pkg::CH_LOW_Z)
              c = c - lbe_pkg::CASE_DIFF;
            else if (req.cmd == lbe_pkg::CMD_LOWER && c >= lbe_pkg::CH_UP_A
                     && c <= lbe_pkg::CH_UP_Z)
              c = c + lbe_pkg::CASE_DIFF;
            cells[cursor] = c;
            push_result(lbe_pkg::KIND_ECHO, c, int'(cursor), 1'b1);
            return;
          end
        end
        lbe_pkg::CMD_BKSP: begin
          // Step back, then shift the tail left with a zero at the end
          if (cursor > 0) cursor = cursor - 7'd1;
          if (int'(cursor) < len) begin
            for (i = int'(cursor); i < len; i++) begin
              cells[i] = (i + 1 < len) ? cells[i + 1] : 8'h00;
              push_result(lbe_pkg::KIND_REDRAW, cells[i], i, i + 1 == len);
            end
            return;
          end
        end
        lbe_pkg::CMD_PRINT: begin
          if (len > 0) begin
            for (i = 0; i < len; i++)
              push_result(lbe_pkg::KIND_PRINT, cells[i], i, i + 1 == len);
            return;
          end
        end
        default: ;
      endcase
      push_result(lbe_pkg::KIND_CURSOR, 8'h00, 0, 1'b1);
    endfunction

    // Compare one emitted result with the oldest expectation
    function void check_result(lbe_pkg::out_res_t got);
      lbe_pkg::out_res_t exp_res;
      results++;
      if (pending_results.size() == 0) begin
        $error("unexpected result: kind %0d char %02h column %0d", got.kind, got.char_out,
               got.column);
        errors++;
        return;
      end
      exp_res = pending_results.pop_front();
      if (got.kind !== exp_res.kind) begin
        $error("kind: expected %0d, got %0d", exp_res.kind, got.kind);
        errors++;
      end
      if (got.char_out !== exp_res.char_out) begin
        $error("char_out: expected %02h, got %02h", exp_res.char_out, got.char_out);
        errors++;
      end
      if (got.column !== exp_res.column) begin
        $error("column: expected %0d, got %0d", exp_res.column, got.column);
        errors++;
      end
      if (got.cursor_pos !== exp_res.cursor_pos) begin
        $error("cursor_pos: expected %0d, got %0d", exp_res.cursor_pos, got.cursor_pos);
        errors++;
      end
      if (got.last !== exp_res.last) begin
        $error("last: expected %0d, got %0d", exp_res.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  lbe_pkg::in_req_t in_req = '0;
  logic out_valid;
  lbe_pkg::out_res_t out_res;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [6:0] cfg_data = 7'd0;

  line_scoreboard board = new();
  int length_settings = 0;

  line_buffer_editor uut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_req(in_req),
    .out_valid(out_valid),
    .out_res(out_res),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // Watch every handshake at the clock edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) board.set_length(cfg_data);
      if (start && !busy) board.note_keystroke(in_req);
      if (out_valid) board.check_result(out_res);
    end
  end

  // Hold start idle at random, then present one request until accepted
  task automatic send_keystroke(input logic [2:0] code, input logic [7:0] ch,
                                input int idle_pct);
    lbe_pkg::in_req_t req;
    req.cmd = code;
    req.char_code = ch;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    start <= 1'b1;
    in_req <= req;
    do @(posedge clk); while (busy);
  endtask

  // Drop start and wait for every queued result plus a settle time
  task automatic wait_quiet();
    start <= 1'b0;
    while (board.pending_results.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_length(input logic [6:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    length_settings++;
  endtask

  // Mostly edits of letters, with boundary characters and raw bytes mixed in
  function automatic lbe_pkg::in_req_t random_keystroke();
    lbe_pkg::in_req_t req;
    int pick;
    logic [7:0] edges [4];
    edges = '{8'h40, 8'h5B, 8'h60, 8'h7B};
    pick = $urandom_range(99);
    if (pick < 36) req.cmd = lbe_pkg::CMD_WRITE;
    else if (pick < 48) req.cmd = lbe_pkg::CMD_LEFT;
    else if (pick < 58) req.cmd = lbe_pkg::CMD_RIGHT;
    else if (pick < 67) req.cmd = lbe_pkg::CMD_UPPER;
    else if (pick < 76) req.cmd = lbe_pkg::CMD_LOWER;
    else if (pick < 89) req.cmd = lbe_pkg::CMD_BKSP;
    else if (pick < 96) req.cmd = lbe_pkg::CMD_PRINT;
    else req.cmd = CMD_UNUSED;
    pick = $urandom_range(9);
    if (pick < 3) req.char_code = lbe_pkg::CH_LOW_A + 8'($urandom_range(25));
    else if (pick < 6) req.char_code = lbe_pkg::CH_UP_A + 8'($urandom_range(25));
    else if (pick < 7) req.char_code = edges[$urandom_range(3)];
    else req.char_code = 8'($urandom);
    return req;
  endfunction

  initial begin
    logic [6:0] phase_len [RANDOM_PHASES];
    int idle_modes [3];
    lbe_pkg::in_req_t req;
    phase_len = '{7'd5, 7'd64, 7'd1, 7'd0, 7'd127, 7'd9, 7'd100, 7'd0};
    idle_modes = '{0, 74, 24};
    phase_len[RANDOM_PHASES - 1] = 7'($urandom_range(1, LINE_CELLS));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed edits on the full line after reset
    send_keystroke(lbe_pkg::CMD_PRINT, 8'h00, 0);
    send_keystroke(lbe_pkg::CMD_LEFT, 8'h00, 0);
    send_keystroke(lbe_pkg::CMD_BKSP, 8'h00, 0);
    send_keystroke(lbe_pkg::CMD_UPPER, 8'h00, 0);
    send_keystroke(lbe_pkg::CMD_WRITE, lbe_pkg::CH_LOW_A, 0);
    send_keystroke(lbe_pkg::CMD_LEFT, 8'h00, 0);
    send_keystroke(lbe_pkg::CMD_UPPER, 8'h00, 0);
    send_keystroke(lbe_pkg::CMD_LOWER, 8'h00, 0);
    send_keystroke(lbe_pkg::CMD_WRITE, lbe_pkg::CH_LOW_Z, 0);
    send_keystroke(lbe_pkg::CMD_WRITE, lbe_pkg::CH_UP_Z, 0);
    send_keystroke(lbe_pkg::CMD_WRITE, 8'h60, 0);
    send_keystroke(lbe_pkg::CMD_WRITE, 8'h7B, 0);
    send_keystroke(lbe_pkg::CMD_WRITE, 8'h40, 0);
    send_keystroke(lbe_pkg::CMD_WRITE, 8'h5B, 0);
    send_keystroke(lbe_pkg::CMD_WRITE, 8'hFF, 0);
    send_keystroke(lbe_pkg::CMD_WRITE, 8'h00, 0);
    send_keystroke(lbe_pkg::CMD_RIGHT, 8'h00, 0);
    send_keystroke(lbe_pkg::CMD_LEFT, 8'h00, 0);
    send_keystroke(lbe_pkg::CMD_LOWER, 8'h00, 0);
    send_keystroke(lbe_pkg::CMD_BKSP, 8'h00, 0);
    send_keystroke(CMD_UNUSED, 8'hA5, 0);
    send_keystroke(lbe_pkg::CMD_PRINT, 8'h00, 0);

    // Random phases, each with its own line length and one of three idle patterns
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_quiet();
      write_length(phase_len[phase]);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        req = random_keystroke();
        // Leave a burst at the start of each phase with no idling
        send_keystroke(req.cmd, req.char_code, (n < 6) ? 0 : idle_modes[phase % 3]);
      end
    end

    wait_quiet();
    if (board.pending_results.size() > 0) begin
      $error("%0d expected results never arrived", board.pending_results.size());
      board.errors++;
    end
    $display("Run covered %0d keystrokes and %0d results over %0d line lengths,",
             board.keystrokes, board.results, length_settings + 1);
    $display("including empty, single-cell, full and oversized lines.");
    if (board.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Bound the run well past the slowest legal schedule
  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
